FILE: hw/rtl/ssm_pkg.sv
package ssm_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LOUD_LEVEL      = 3'd0,
        CFG_WALL_THRESHOLD  = 3'd1,
        CFG_TURN_FLOOR      = 3'd2,
        CFG_CRUISE_SPEED    = 3'd3,
        CFG_PROP_GAIN       = 3'd4,
        CFG_DERIV_GAIN      = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MODE_SILENCE = 3'b001,
        MODE_SEEK    = 3'b010,
        MODE_WALL    = 3'b100
    } mode_t;

    localparam logic [1:0] MODE_CODE_SILENCE = 2'd0;
    localparam logic [1:0] MODE_CODE_SEEK    = 2'd1;
    localparam logic [1:0] MODE_CODE_WALL    = 2'd2;

    localparam logic [3:0] SEL_STOP_ON_SILENCE = 4'd7;
    localparam logic [3:0] SEL_ZERO_CRUISE     = 4'd8;

    localparam logic [23:0]        LOUD_LEVEL_RST         = 24'd1000;
    localparam logic [11:0]        WALL_THRESHOLD_RST     = 12'd110;
    localparam logic [14:0]        TURN_FLOOR_RST         = 15'd10;
    localparam logic signed [15:0] CRUISE_SPEED_RST       = 16'sd500;
    localparam logic [19:0]        PROP_GAIN_RST          = 20'd19661;
    localparam logic [19:0]        DERIV_GAIN_RST         = 20'd0;

    typedef struct packed {
        logic [1:0]         mode_code;
        logic               lights;
        logic               write;
        logic               siren;
        logic               seek;
        logic               steer_on;
        logic               zero_cruise;
        logic               force_stop;
        logic signed [25:0] diff;
        logic signed [26:0] delta;
    } step_ctl_t;

    typedef struct packed {
        logic [1:0]         mode_code;
        logic               write;
        logic signed [15:0] right_speed;
        logic signed [15:0] left_speed;
        logic               lights;
        logic               siren;
    } step_res_t;

endpackage

FILE: hw/rtl/ssm_mode_fsm.sv
module ssm_mode_fsm (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  logic [11:0]        prox_left,
    input  logic [11:0]        prox_right,
    input  logic signed [24:0] sound_left,
    input  logic signed [24:0] sound_right,
    input  logic [3:0]         selector,
    input  logic [23:0]        loud_level,
    input  logic [11:0]        wall_threshold,
    output ssm_pkg::step_ctl_t ctl
);
    import ssm_pkg::*;

    mode_t              mode_reg;
    mode_t              mode_next;
    logic               lights_reg;
    logic               lights_next;
    logic signed [25:0] last_error_reg;
    logic signed [25:0] last_error_next;

    logic               wall;
    logic               snd;
    logic signed [25:0] thr_s;
    logic signed [25:0] diff;
    logic [25:0]        mag;
    logic               steer_hit;

    assign thr_s = $signed({2'b00, loud_level});
    assign wall  = (prox_left > wall_threshold) || (prox_right > wall_threshold);
    assign snd   = ($signed({sound_left[24], sound_left}) > thr_s)
                || ($signed({sound_right[24], sound_right}) > thr_s);
    assign diff  = $signed({sound_right[24], sound_right})
                 - $signed({sound_left[24], sound_left});
    assign mag   = diff[25] ? (~diff + 26'd1) : diff;
    assign steer_hit = mag >= {2'b00, loud_level};

    always_comb
    begin
        mode_next       = mode_reg;
        lights_next     = lights_reg;
        last_error_next = last_error_reg;
        ctl             = '0;
        ctl.diff        = diff;
        ctl.delta       = $signed({diff[25], diff})
                        - $signed({last_error_reg[25], last_error_reg});
        case (mode_reg)
            MODE_SILENCE:
            begin
                if (snd)
                begin
                    lights_next = 1'b1;
                    mode_next   = MODE_SEEK;
                end
                else
                begin
                    lights_next = 1'b0;
                end
            end
            MODE_SEEK:
            begin
                ctl.write       = 1'b1;
                ctl.seek        = 1'b1;
                ctl.zero_cruise = (selector == SEL_ZERO_CRUISE);
                lights_next     = 1'b1;
                if (steer_hit)
                begin
                    ctl.steer_on    = 1'b1;
                    last_error_next = diff;
                end
                if (wall)
                begin
                    mode_next = MODE_WALL;
                end
                if (!snd && (selector == SEL_STOP_ON_SILENCE))
                begin
                    ctl.force_stop = 1'b1;
                    mode_next      = MODE_SILENCE;
                end
            end
            MODE_WALL:
            begin
                ctl.write = 1'b1;
                ctl.siren = 1'b1;
                if (!wall || !snd)
                begin
                    mode_next = MODE_SILENCE;
                end
                if (!wall && snd)
                begin
                    mode_next = MODE_SEEK;
                end
            end
            default:
            begin
            end
        endcase
        case (mode_next)
            MODE_SEEK: ctl.mode_code = MODE_CODE_SEEK;
            MODE_WALL: ctl.mode_code = MODE_CODE_WALL;
            default:   ctl.mode_code = MODE_CODE_SILENCE;
        endcase
        ctl.lights = lights_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_SILENCE;
            lights_reg     <= 1'b0;
            last_error_reg <= '0;
        end
        else if (step_en)
        begin
            mode_reg       <= mode_next;
            lights_reg     <= lights_next;
            last_error_reg <= last_error_next;
        end
    end

endmodule

FILE: hw/rtl/ssm_pd_steer.sv
module ssm_pd_steer (
    input  logic               clk,
    input  logic               load,
    input  ssm_pkg::step_ctl_t ctl,
    input  logic [19:0]        prop_gain,
    input  logic [19:0]        deriv_gain,
    input  logic [14:0]        turn_floor,
    input  logic signed [15:0] cruise_speed,
    output ssm_pkg::step_res_t res
);
    import ssm_pkg::*;

    function automatic logic signed [15:0] sat_wide(input logic signed [32:0] v);
        logic signed [15:0] r;
        if (v > 33'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -33'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat_narrow(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v[16] != v[15])
        begin
            r = v[16] ? 16'sh8000 : 16'sh7FFF;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    logic signed [20:0] prop_s;
    logic signed [20:0] deriv_s;
    logic signed [46:0] prop_prod_next;
    logic signed [47:0] deriv_prod_next;
    logic signed [46:0] prop_prod_reg;
    logic signed [47:0] deriv_prod_reg;
    step_ctl_t          ctl_reg;

    logic signed [48:0] sum;
    logic signed [48:0] sum_adj;
    logic signed [32:0] quot;
    logic signed [15:0] corr_sat;
    logic [16:0]        corr_mag;
    logic signed [15:0] corr;
    logic signed [15:0] speed;
    logic signed [15:0] right_raw;
    logic signed [15:0] left_raw;

    assign prop_s          = $signed({1'b0, prop_gain});
    assign deriv_s         = $signed({1'b0, deriv_gain});
    assign prop_prod_next  = prop_s * ctl.diff;
    assign deriv_prod_next = deriv_s * ctl.delta;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prop_prod_reg  <= prop_prod_next;
            deriv_prod_reg <= deriv_prod_next;
            ctl_reg        <= ctl;
        end
    end

    // The quotient by 65536 truncates toward zero, so negative sums get a bias first.
    assign sum      = 49'(prop_prod_reg) + 49'(deriv_prod_reg);
    assign sum_adj  = sum[48] ? (sum + 49'sd65535) : sum;
    assign quot     = 33'(sum_adj >>> 16);
    assign corr_sat = ctl_reg.steer_on ? sat_wide(quot) : 16'sd0;
    assign corr_mag = corr_sat[15] ? (17'd0 - {1'b1, corr_sat}) : {1'b0, corr_sat};
    assign corr     = (corr_mag < {2'b00, turn_floor}) ? 16'sd0 : corr_sat;
    assign speed    = ctl_reg.zero_cruise ? 16'sd0 : cruise_speed;
    assign right_raw = sat_narrow(17'(speed) + 17'(corr));
    assign left_raw  = sat_narrow(17'(speed) - 17'(corr));

    always_comb
    begin
        res.mode_code = ctl_reg.mode_code;
        res.write     = ctl_reg.write;
        res.lights    = ctl_reg.lights;
        res.siren     = ctl_reg.siren;
        if (ctl_reg.seek && !ctl_reg.force_stop)
        begin
            res.right_speed = right_raw;
            res.left_speed  = left_raw;
        end
        else
        begin
            res.right_speed = 16'sd0;
            res.left_speed  = 16'sd0;
        end
    end

endmodule

FILE: hw/rtl/sound_seek_mode_pd_steering_unit.sv
// Sound-seeking steering controller for a small wheeled robot.
// One input transaction carries a control tick: two front proximity readings,
// two microphone intensities and the selector position. Each tick produces
// exactly one output transaction with the mode after the tick, the wheel
// speed commands, the motor write flag, the lights flag and the siren request.
// Both channels use valid and ready. The configuration port writes one
// register per cycle with cfg_write_en and must only be used while idle.
// The pipeline has four register stages: input, mode update, gain products
// and output. An accepted tick passes the mode update, gain product and output
// registers in turn; one tick is accepted every cycle when the output is taken.
// The products of the two 20-bit gains with the intensity error set the
// stage split. When the receiver stalls, the output register holds its
// transaction and the earlier stages keep filling until all are occupied.
// Reset clears the pipeline, puts the controller in silence mode with the
// lights off and a zero stored error, and loads the default register values.
module sound_seek_mode_pd_steering_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [ssm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ssm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [11:0]                         prox_front_left,
    input  logic [11:0]                         prox_front_right,
    input  logic signed [24:0]                  sound_left,
    input  logic signed [24:0]                  sound_right,
    input  logic [3:0]                          selector_pos,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          mode_now,
    output logic                                motor_write,
    output logic signed [15:0]                  right_speed,
    output logic signed [15:0]                  left_speed,
    output logic                                lights_on,
    output logic                                siren_request
);
    import ssm_pkg::*;

    logic [23:0]        loud_level_reg;
    logic [11:0]        wall_threshold_reg;
    logic [14:0]        turn_floor_reg;
    logic signed [15:0] cruise_speed_reg;
    logic [19:0]        prop_gain_reg;
    logic [19:0]        deriv_gain_reg;

    logic               in_valid_reg;
    logic [11:0]        prox_left_reg;
    logic [11:0]        prox_right_reg;
    logic signed [24:0] sound_left_reg;
    logic signed [24:0] sound_right_reg;
    logic [3:0]         selector_reg;

    logic               ctl_valid_reg;
    step_ctl_t          ctl_next;
    step_ctl_t          ctl_reg;
    logic               prod_valid_reg;
    logic               out_valid_reg;
    step_res_t          res_next;
    step_res_t          res_reg;

    logic               load_out;
    logic               load_prod;
    logic               load_ctl;

    assign load_out  = !out_valid_reg || out_ready;
    assign load_prod = !prod_valid_reg || load_out;
    assign load_ctl  = !ctl_valid_reg || load_prod;
    assign in_ready  = !in_valid_reg || load_ctl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loud_level_reg         <= LOUD_LEVEL_RST;
            wall_threshold_reg     <= WALL_THRESHOLD_RST;
            turn_floor_reg         <= TURN_FLOOR_RST;
            cruise_speed_reg       <= CRUISE_SPEED_RST;
            prop_gain_reg          <= PROP_GAIN_RST;
            deriv_gain_reg         <= DERIV_GAIN_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_LOUD_LEVEL:         loud_level_reg         <= cfg_data[23:0];
                CFG_WALL_THRESHOLD:     wall_threshold_reg     <= cfg_data[11:0];
                CFG_TURN_FLOOR:         turn_floor_reg         <= cfg_data[14:0];
                CFG_CRUISE_SPEED:       cruise_speed_reg       <= cfg_data[15:0];
                CFG_PROP_GAIN:          prop_gain_reg          <= cfg_data[19:0];
                CFG_DERIV_GAIN:         deriv_gain_reg         <= cfg_data[19:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            ctl_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (load_ctl)
            begin
                ctl_valid_reg <= in_valid_reg;
            end
            if (load_prod)
            begin
                prod_valid_reg <= ctl_valid_reg;
            end
            if (load_out)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            prox_left_reg   <= prox_front_left;
            prox_right_reg  <= prox_front_right;
            sound_left_reg  <= sound_left;
            sound_right_reg <= sound_right;
            selector_reg    <= selector_pos;
        end
        if (load_ctl)
        begin
            ctl_reg <= ctl_next;
        end
        if (load_out)
        begin
            res_reg <= res_next;
        end
    end

    ssm_mode_fsm u_mode_fsm (
        .clk             (clk),
        .rst_n           (rst_n),
        .step_en         (in_valid_reg && load_ctl),
        .prox_left       (prox_left_reg),
        .prox_right      (prox_right_reg),
        .sound_left      (sound_left_reg),
        .sound_right     (sound_right_reg),
        .selector        (selector_reg),
        .loud_level      (loud_level_reg),
        .wall_threshold  (wall_threshold_reg),
        .ctl             (ctl_next)
    );

    ssm_pd_steer u_pd_steer (
        .clk                (clk),
        .load               (load_prod),
        .ctl                (ctl_reg),
        .prop_gain          (prop_gain_reg),
        .deriv_gain         (deriv_gain_reg),
        .turn_floor         (turn_floor_reg),
        .cruise_speed       (cruise_speed_reg),
        .res                (res_next)
    );

    assign out_valid     = out_valid_reg;
    assign mode_now      = res_reg.mode_code;
    assign motor_write   = res_reg.write;
    assign right_speed   = res_reg.right_speed;
    assign left_speed    = res_reg.left_speed;
    assign lights_on     = res_reg.lights;
    assign siren_request = res_reg.siren;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

import ssm_pkg::*;

typedef struct {
    logic [11:0]        prox_l;
    logic [11:0]        prox_r;
    logic signed [24:0] snd_l;
    logic signed [24:0] snd_r;
    logic [3:0]         sel;
} tick_t;

class wheel_cmd_predictor;
    logic [23:0]        sound_thr;
    logic [11:0]        wall_thr;
    logic [14:0]        rot_thr;
    logic signed [15:0] cruise;
    logic [19:0]        prop_gain;
    logic [19:0]        deriv_gain;
    logic [1:0]         mode_code;
    logic signed [25:0] last_err;
    logic               lights;
    step_res_t          pending_cmds[$];
    int                 errors;

    function new();
        sound_thr = LOUD_LEVEL_RST;
        wall_thr = WALL_THRESHOLD_RST;
        rot_thr = TURN_FLOOR_RST;
        cruise = CRUISE_SPEED_RST;
        prop_gain = PROP_GAIN_RST;
        deriv_gain = DERIV_GAIN_RST;
        mode_code = MODE_CODE_SILENCE;
        last_err = '0;
        lights = 1'b0;
        errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [23:0] val);
        case (idx)
            CFG_LOUD_LEVEL:         sound_thr = val;
            CFG_WALL_THRESHOLD:     wall_thr = val[11:0];
            CFG_TURN_FLOOR:         rot_thr = val[14:0];
            CFG_CRUISE_SPEED:       cruise = val[15:0];
            CFG_PROP_GAIN:          prop_gain = val[19:0];
            CFG_DERIV_GAIN:         deriv_gain = val[19:0];
            default:                ;
        endcase
    endfunction

    function logic signed [15:0] sat_speed(longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function void note_tick(tick_t t);
        step_res_t r;
        bit        wall;
        bit        loud;
        longint    diff;
        longint    mag;
        longint    sum;
        longint    corr;
        longint    speed;
        r = '0;
        wall = t.prox_l > wall_thr || t.prox_r > wall_thr;
        loud = longint'(t.snd_l) > longint'(sound_thr) ||
               longint'(t.snd_r) > longint'(sound_thr);
        case (mode_code)
            MODE_CODE_SILENCE:
            begin
                if (loud)
                begin
                    lights = 1'b1;
                    mode_code = MODE_CODE_SEEK;
                end
                else
                begin
                    lights = 1'b0;
                end
            end
            MODE_CODE_SEEK:
            begin
                diff = longint'(t.snd_r) - longint'(t.snd_l);
                mag = diff < 0 ? -diff : diff;
                corr = 0;
                lights = 1'b1;
                if (mag >= longint'(sound_thr))
                begin
                    sum = longint'(prop_gain) * diff +
                          longint'(deriv_gain) * (diff - longint'(last_err));
                    corr = longint'(sat_speed(sum / 65536));
                    last_err = diff[25:0];
                end
                if ((corr < 0 ? -corr : corr) < longint'(rot_thr))
                    corr = 0;
                speed = (t.sel == SEL_ZERO_CRUISE) ? 0 : longint'(cruise);
                r.right_speed = sat_speed(speed + corr);
                r.left_speed = sat_speed(speed - corr);
                r.write = 1'b1;
                if (wall)
                    mode_code = MODE_CODE_WALL;
                if (!loud && t.sel == SEL_STOP_ON_SILENCE)
                begin
                    r.right_speed = '0;
                    r.left_speed = '0;
                    mode_code = MODE_CODE_SILENCE;
                end
            end
            MODE_CODE_WALL:
            begin
                r.write = 1'b1;
                if (!wall || !loud)
                    mode_code = MODE_CODE_SILENCE;
                if (!wall && loud)
                    mode_code = MODE_CODE_SEEK;
                r.siren = 1'b1;
            end
            default:
                ;
        endcase
        r.mode_code = mode_code;
        r.lights = lights;
        pending_cmds.push_back(r);
    endfunction

    function void compare_field(string name, logic signed [16:0] want,
                                logic signed [16:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    function void check_cmd(step_res_t got);
        step_res_t want;
        if (pending_cmds.size() == 0)
        begin
            errors++;
            $display("%0t: result with no tick waiting, expected none actual mode %0d",
                     $time, got.mode_code);
            return;
        end
        want = pending_cmds.pop_front();
        compare_field("mode_now", want.mode_code, got.mode_code);
        compare_field("motor_write", want.write, got.write);
        compare_field("right_speed", want.right_speed, got.right_speed);
        compare_field("left_speed", want.left_speed, got.left_speed);
        compare_field("lights_on", want.lights, got.lights);
        compare_field("siren_request", want.siren, got.siren);
    endfunction
endclass

module tb;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [11:0]            prox_front_left;
    logic [11:0]            prox_front_right;
    logic signed [24:0]     sound_left;
    logic signed [24:0]     sound_right;
    logic [3:0]             selector_pos;
    logic                   out_valid;
    logic                   out_ready;
    logic [1:0]             mode_now;
    logic                   motor_write;
    logic signed [15:0]     right_speed;
    logic signed [15:0]     left_speed;
    logic                   lights_on;
    logic                   siren_request;

    wheel_cmd_predictor pred = new();
    int                 ticks_sent = 0;

    sound_seek_mode_pd_steering_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .prox_front_left  (prox_front_left),
        .prox_front_right (prox_front_right),
        .sound_left       (sound_left),
        .sound_right      (sound_right),
        .selector_pos     (selector_pos),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .mode_now         (mode_now),
        .motor_write      (motor_write),
        .right_speed      (right_speed),
        .left_speed       (left_speed),
        .lights_on        (lights_on),
        .siren_request    (siren_request)
    );

    always #5 clk = ~clk;

    function automatic tick_t mk_tick(int pl, int pr, int sl, int sr, int sel);
        tick_t t;
        t.prox_l = pl[11:0];
        t.prox_r = pr[11:0];
        t.snd_l = sl[24:0];
        t.snd_r = sr[24:0];
        t.sel = sel[3:0];
        return t;
    endfunction

    function automatic logic signed [24:0] sound_level(bit loud);
        int thr;
        int kind;
        int v;
        thr = pred.sound_thr;
        kind = $urandom_range(0, 9);
        if (kind == 0)
            return 25'($urandom);
        case (kind)
            1:       v = thr + $urandom_range(0, 2) - 1;
            2:       v = $urandom_range(0, 1) ? 16777215 : -16777216;
            default: v = loud ? thr + 1 + $urandom_range(0, 30000)
                              : thr - $urandom_range(0, 30000);
        endcase
        if (v > 16777215)
            v = 16777215;
        if (v < -16777216)
            v = -16777216;
        return v[24:0];
    endfunction

    function automatic logic [11:0] prox_level(bit wall);
        int thr;
        thr = pred.wall_thr;
        if ($urandom_range(0, 9) == 0)
            return 12'($urandom);
        if (wall && thr < 4095)
            return 12'($urandom_range(thr + 1, 4095));
        return 12'($urandom_range(0, thr));
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        bit    want_loud;
        bit    want_wall;
        int    side;
        int    r;
        int    v;
        want_loud = $urandom_range(0, 3) != 0;
        want_wall = $urandom_range(0, 4) == 0;
        side = $urandom_range(0, 1);
        t.prox_l = prox_level(want_wall && side == 0);
        t.prox_r = prox_level(want_wall && side == 1);
        side = $urandom_range(0, 1);
        t.snd_l = sound_level(want_loud && side == 0);
        t.snd_r = sound_level(want_loud && side == 1);
        if (want_loud && $urandom_range(0, 2) == 0)
        begin
            v = (side == 0) ? int'(t.snd_l) : int'(t.snd_r);
            v = v + $urandom_range(0, 6000) - 3000;
            if (v > 16777215)
                v = 16777215;
            if (v < -16777216)
                v = -16777216;
            if (side == 0)
                t.snd_r = v[24:0];
            else
                t.snd_l = v[24:0];
        end
        r = $urandom_range(0, 9);
        if (r < 2)
            t.sel = SEL_STOP_ON_SILENCE;
        else if (r < 4)
            t.sel = SEL_ZERO_CRUISE;
        else
            t.sel = 4'($urandom);
        return t;
    endfunction

    task automatic offer_tick(tick_t t);
        in_valid <= 1'b1;
        prox_front_left <= t.prox_l;
        prox_front_right <= t.prox_r;
        sound_left <= t.snd_l;
        sound_right <= t.snd_r;
        selector_pos <= t.sel;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pred.note_tick(t);
        ticks_sent++;
    endtask

    task automatic run_random(int count);
        int left;
        int burst;
        int gap;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && left > 0)
            begin
                offer_tick(random_tick());
                burst--;
                left--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        pred.write_reg(idx, val);
    endtask

    task automatic apply_settings(logic [23:0] thr, logic [11:0] wall, logic [14:0] rot,
                                  logic signed [15:0] speed, logic [19:0] kp,
                                  logic [19:0] kd);
        in_valid <= 1'b0;
        while (pred.pending_cmds.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        write_reg(CFG_LOUD_LEVEL, thr);
        write_reg(CFG_WALL_THRESHOLD, 24'(wall));
        write_reg(CFG_TURN_FLOOR, 24'(rot));
        write_reg(CFG_CRUISE_SPEED, 24'(speed));
        write_reg(CFG_PROP_GAIN, 24'(kp));
        write_reg(CFG_DERIV_GAIN, 24'(kd));
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin : result_monitor
        step_res_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.mode_code = mode_now;
            got.write = motor_write;
            got.right_speed = right_speed;
            got.left_speed = left_speed;
            got.lights = lights_on;
            got.siren = siren_request;
            pred.check_cmd(got);
        end
    end

    // The receiver mixes free-running, random, toggling and mostly-stalled
    // stretches, and now and then holds off long enough to back up the input.
    initial
    begin : receiver
        int kind;
        int seg;
        int next_hold_at;
        next_hold_at = 400;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (ticks_sent >= next_hold_at)
            begin
                next_hold_at += 900;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            kind = $urandom_range(0, 3);
            seg = $urandom_range(10, 120);
            repeat (seg)
            begin
                case (kind)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= ~out_ready;
                    default: out_ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int guard;
        rst_n <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index <= CFG_LOUD_LEVEL;
        cfg_data <= '0;
        in_valid <= 1'b0;
        prox_front_left <= '0;
        prox_front_right <= '0;
        sound_left <= '0;
        sound_right <= '0;
        selector_pos <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_tick(mk_tick(0, 0, 0, 0, 0));
        offer_tick(mk_tick(4095, 4095, -16777216, -16777216, 15));
        offer_tick(mk_tick(0, 0, 1000, 1000, 0));
        offer_tick(mk_tick(0, 0, 1001, 0, 0));
        offer_tick(mk_tick(0, 0, -16777216, 16777215, 0));
        offer_tick(mk_tick(0, 0, 16777215, -16777216, 0));
        offer_tick(mk_tick(0, 0, 5000, 5500, 0));
        offer_tick(mk_tick(0, 0, 5000, 6000, 0));
        offer_tick(mk_tick(0, 0, 2000, 8000, SEL_ZERO_CRUISE));
        offer_tick(mk_tick(110, 110, 3000, 2000, SEL_STOP_ON_SILENCE));
        offer_tick(mk_tick(4095, 0, 0, 0, SEL_STOP_ON_SILENCE));
        offer_tick(mk_tick(0, 0, 0, 0, 0));
        offer_tick(mk_tick(0, 0, 0, 20000, 0));
        offer_tick(mk_tick(0, 111, 20000, 20000, 0));
        offer_tick(mk_tick(200, 0, 2000, 0, 0));
        offer_tick(mk_tick(0, 0, 2000, 0, 0));
        offer_tick(mk_tick(4095, 0, 2000, 2000, 0));
        offer_tick(mk_tick(4095, 4095, 0, 0, 0));
        offer_tick(mk_tick(0, 0, 0, 0, 0));
        offer_tick(mk_tick(0, 0, 16777215, 0, 0));
        offer_tick(mk_tick(0, 0, 500, -500, 6));
        offer_tick(mk_tick(0, 2000, 0, 5000, 0));
        offer_tick(mk_tick(0, 0, 0, 0, 0));
        offer_tick(mk_tick(0, 0, 0, 4000, SEL_ZERO_CRUISE));

        run_random(300);
        apply_settings(24'd0, 12'd0, 15'd0, -16'sd32768, 20'd0, 20'd0);
        run_random(150);
        apply_settings(24'hffffff, 12'hfff, 15'h7fff, 16'sd32767, 20'hfffff, 20'hfffff);
        run_random(100);
        apply_settings(24'd500, 12'd2047, 15'd0, 16'sd32767, 20'hfffff, 20'hfffff);
        run_random(300);
        repeat (3)
        begin
            apply_settings(24'($urandom_range(0, 8000)), 12'($urandom_range(50, 4000)),
                           15'($urandom_range(0, 3000)), 16'($urandom),
                           20'($urandom), 20'($urandom));
            run_random(360);
        end

        in_valid <= 1'b0;
        for (guard = 0; guard < 20000 && pred.pending_cmds.size() != 0; guard++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (pred.errors == 0 && pred.pending_cmds.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #(5_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
